FILE: hw/rtl/bmbd_pkg.sv
`default_nettype none

package bmbd_pkg;

   localparam int MAX_BANKS_DEF   = 16;
   localparam int PLANE_BYTES_DEF = 65536;

   localparam int KIND_W   = 3;
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int ATTR_W   = 2;
   localparam int BANK_W   = 4;
   localparam int CARD_W   = 3;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 3;
   localparam int PAGES    = 256;
   localparam int PAGE_W   = 8;
   localparam int NBANK_W  = 5;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic [KIND_W-1:0] KIND_MEM_RD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MEM_WR   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IO_RD    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_IO_WR    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET_PAGE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RESET    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd6;

   localparam logic [ATTR_W-1:0] PAGE_NONE = 2'd0;
   localparam logic [ATTR_W-1:0] PAGE_RAM  = 2'd1;
   localparam logic [ATTR_W-1:0] PAGE_ROM  = 2'd2;

   localparam logic [CARD_W-1:0] CARD_NONE = 3'd0;
   localparam logic [CARD_W-1:0] CARD_ERAM = 3'd1;
   localparam logic [CARD_W-1:0] CARD_VRAM = 3'd2;
   localparam logic [CARD_W-1:0] CARD_CRAM = 3'd3;
   localparam logic [CARD_W-1:0] CARD_HRAM = 3'd4;
   localparam logic [CARD_W-1:0] CARD_B810 = 3'd5;

   localparam logic [MODE_W-1:0] MODE_NEVER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALL   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CARD_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HONOR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ASSERT    = 2'd2;

   localparam logic [DATA_W-1:0] VRAM_BIT6_MASK = 8'hBF;

   typedef struct packed {
      logic capture;
      logic divide;
      logic remainder;
      logic locate;
      logic access;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0]  port_num;
      logic [NBANK_W-1:0] banks;
      logic               one_hot;
      logic [DATA_W-1:0]  mask;
      logic               has_port;
   } card_spec_type;

   function automatic card_spec_type card_spec_of(input logic [CARD_W-1:0] card);
      card_spec_type s;
      s = '{port_num: 8'h00, banks: 5'd1, one_hot: 1'b0, mask: 8'hFF, has_port: 1'b0};
      case (card)
         CARD_ERAM: s = '{port_num: 8'hFF, banks: 5'd8, one_hot: 1'b0, mask: 8'h07,
                          has_port: 1'b1};
         CARD_VRAM: s = '{port_num: 8'h40, banks: 5'd8, one_hot: 1'b1, mask: 8'hFF,
                          has_port: 1'b1};
         CARD_CRAM: s = '{port_num: 8'h40, banks: 5'd7, one_hot: 1'b1, mask: 8'h7F,
                          has_port: 1'b1};
         CARD_HRAM: s = '{port_num: 8'hC0, banks: 5'd16, one_hot: 1'b0, mask: 8'h0F,
                          has_port: 1'b1};
         CARD_B810: s = '{port_num: 8'h40, banks: 5'd16, one_hot: 1'b0, mask: 8'h0F,
                          has_port: 1'b1};
         default:   s = '{port_num: 8'h00, banks: 5'd1, one_hot: 1'b0, mask: 8'hFF,
                          has_port: 1'b0};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/banked_memory_board_bus_decode_core.sv
`default_nettype none

// Channel  Ports                   Contents
// req      req_tvalid/tready/...   one bus cycle or housekeeping action, kind in tuser
// rsp      rsp_tvalid/tready/...   answer, PHANTOM, read byte, reject, bank latch
// csr      csr_valid/ready/...     card type and the two PHANTOM jumpers
//
// After the accepting edge an item passes through divide, remainder, locate, store access
// and result load, in that order; the load waits while the output register holds a result.
// A new item is accepted only after the last one has loaded its result.
// One item is in work at a time; a result may wait in the output register while
// the next item is accepted. Reset clears the bank latch, the jumpers, the card type
// and the page valid bits at once; the byte store holds no reset contents.

module banked_memory_board_bus_decode_core
   import bmbd_pkg::*;
#(
   parameter int MAX_BANKS   = MAX_BANKS_DEF,
   parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // address[15:0], data[23:16], phantom_in[24], page_attr[26:25], load_bank[30:27]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // kind[2:0]
   input  wire logic [KIND_W-1:0]      req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // answered[0], phantom_driven[1], read_data[9:2], select_rejected[10],
   // current_bank[14:11]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   bmbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bmbd_dp #(
      .MAX_BANKS   (MAX_BANKS),
      .PLANE_BYTES (PLANE_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .kind       (req_tuser),
      .address    (req_tdata[15:0]),
      .data       (req_tdata[23:16]),
      .phantom_in (req_tdata[24]),
      .page_attr  (req_tdata[26:25]),
      .load_bank  (req_tdata[30:27]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   a_read_needs_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || (rsp_tdata[9:2] == 8'd0)))
      else $error("read data without an answered cycle");

   a_reject_needs_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[10]) |-> rsp_tdata[0])
      else $error("select rejected on a cycle that was not decoded");

   a_phantom_not_io: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[10]))
      else $error("PHANTOM driven on a bank-select cycle");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in work");

endmodule

`default_nettype wire

FILE: hw/rtl/bmbd_ram.sv
`default_nettype none

module bmbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0]      rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bmbd_ctrl.sv
`default_nettype none

module bmbd_ctrl
   import bmbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire status_type  status,
   output cmd_type          cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIV    = 3'd1;
   localparam logic [2:0] S_REM    = 3'd2;
   localparam logic [2:0] S_LOCATE = 3'd3;
   localparam logic [2:0] S_ACCESS = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      req_tready    = (state_ff == S_IDLE);
      cmd           = '0;
      state_in      = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            cmd.divide = 1'b1;
            state_in   = S_REM;
         end
         S_REM: begin
            cmd.remainder = 1'b1;
            state_in      = S_LOCATE;
         end
         S_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = S_ACCESS;
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/bmbd_dp.sv
`default_nettype none

module bmbd_dp
   import bmbd_pkg::*;
#(
   parameter int MAX_BANKS   = MAX_BANKS_DEF,
   parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [KIND_W-1:0]     kind,
   input  wire logic [ADDR_W-1:0]     address,
   input  wire logic [DATA_W-1:0]     data,
   input  wire logic                  phantom_in,
   input  wire logic [ATTR_W-1:0]     page_attr,
   input  wire logic [BANK_W-1:0]     load_bank,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int OFF_W   = $clog2(PLANE_BYTES);
   localparam int DEPTH   = MAX_BANKS * PLANE_BYTES;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int RECIP   = (1 << 24) / PLANE_BYTES;
   localparam int PROD_W  = 33;
   localparam int REM_W   = 18;
   localparam int Q_W     = 9;
   localparam int SPAN_W  = 21;

   logic [KIND_W-1:0] kind_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] data_ff;
   logic              ph_in_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [BANK_W-1:0] lbank_ff;

   logic [CARD_W-1:0] card_ff;
   logic [MODE_W-1:0] honor_ff;
   logic [MODE_W-1:0] assert_ff;

   logic [Q_W-1:0]    q_ff;
   logic [OFF_W-1:0]  off_ff;
   logic              mem_ans_ff;
   logic              ph_drv_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic              ans_ff;
   logic              rej_ff;
   logic              latch_we_ff;
   logic [BANK_W-1:0] latch_val_ff;
   logic              store_we_ff;
   logic              rd_use_ff;
   logic [BANK_W-1:0] bank_latch_ff;

   logic [PAGES-1:0]  page_valid_ff;
   logic              page_vld_rd_ff;
   logic [ATTR_W-1:0] page_rd;
   logic              page_we;
   logic [ATTR_W-1:0] page_wdata;
   logic [DATA_W-1:0] store_rd;

   logic              rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [PROD_W-1:0] prod_q;
   logic [REM_W-1:0]  prod_r;
   logic [REM_W-1:0]  rem_a;
   logic [REM_W-1:0]  rem_b;

   logic [ATTR_W-1:0] pk;
   logic              is_read;
   logic              is_mem;
   logic              rom;
   logic              asserts;
   logic              honors;
   logic              mem_ans;

   card_spec_type     spec;
   logic              port_hit;
   logic [DATA_W-1:0] sel_byte;
   logic [DATA_W-1:0] hot_byte;
   logic [BANK_W-1:0] want;
   logic              dec_ok;
   logic [NBANK_W-1:0] nbanks;
   logic              sel_ok;
   logic [BANK_W-1:0] bank_sel;
   logic              load_ok;
   logic [SPAN_W-1:0] span;

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind;
         addr_ff  <= address;
         data_ff  <= data;
         ph_in_ff <= phantom_in;
         attr_ff  <= page_attr;
         lbank_ff <= load_bank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_ff   <= CARD_NONE;
         honor_ff  <= MODE_NEVER;
         assert_ff <= MODE_NEVER;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CARD_TYPE: card_ff   <= csr_data;
            CSR_HONOR:     honor_ff  <= csr_data[MODE_W-1:0];
            CSR_ASSERT:    assert_ff <= csr_data[MODE_W-1:0];
            default:       ;
         endcase
      end
   end

   assign page_we    = cmd.access && (kind_ff == KIND_SET_PAGE);
   assign page_wdata = (attr_ff == PAGE_RAM || attr_ff == PAGE_ROM) ? attr_ff : PAGE_NONE;

   bmbd_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (PAGES)
   ) u_page_ram (
      .clock      (clock),
      .wr_en      (page_we),
      .addr       (addr_ff[ADDR_W-1:ADDR_W-PAGE_W]),
      .wr_data    (page_wdata),
      .rd_data_ff (page_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_valid_ff <= '0;
      end else if (page_we) begin
         page_valid_ff[addr_ff[ADDR_W-1:ADDR_W-PAGE_W]] <= 1'b1;
      end
      page_vld_rd_ff <= page_valid_ff[addr_ff[ADDR_W-1:ADDR_W-PAGE_W]];
   end

   // Offset within a plane: reciprocal estimate, then one correcting subtract.
   assign prod_q = PROD_W'(addr_ff) * PROD_W'(RECIP);
   assign prod_r = REM_W'(q_ff) * REM_W'(PLANE_BYTES);
   assign rem_a  = REM_W'(addr_ff) - prod_r;
   assign rem_b  = (rem_a >= REM_W'(PLANE_BYTES)) ? rem_a - REM_W'(PLANE_BYTES) : rem_a;

   always_comb begin
      pk      = page_vld_rd_ff ? page_rd : PAGE_NONE;
      is_read = (kind_ff == KIND_MEM_RD);
      is_mem  = is_read || (kind_ff == KIND_MEM_WR);
      rom     = (pk == PAGE_ROM);
      asserts = is_mem && rom &&
                ((assert_ff >= MODE_ALL) || ((assert_ff == MODE_READS) && is_read));
      honors  = (honor_ff >= MODE_ALL) || ((honor_ff == MODE_READS) && is_read);
      mem_ans = is_mem && !(ph_in_ff && honors && !asserts) &&
                (pk == PAGE_RAM || pk == PAGE_ROM) && !(!is_read && rom);
   end

   always_comb begin
      spec     = card_spec_of(card_ff);
      port_hit = (kind_ff == KIND_IO_WR) && spec.has_port && (addr_ff[7:0] == spec.port_num);
      sel_byte = data_ff & spec.mask;
      hot_byte = (card_ff == CARD_VRAM) ? (sel_byte & VRAM_BIT6_MASK) : sel_byte;
      want     = sel_byte[BANK_W-1:0];
      dec_ok   = 1'b1;
      if (spec.one_hot) begin
         want   = '0;
         dec_ok = 1'b0;
         for (int i = 0; i < DATA_W; i++) begin
            if (hot_byte == (DATA_W'(1) << i)) begin
               want   = BANK_W'(i);
               dec_ok = 1'b1;
            end
         end
      end
      nbanks   = (spec.banks < NBANK_W'(MAX_BANKS)) ? spec.banks : NBANK_W'(MAX_BANKS);
      sel_ok   = dec_ok && (NBANK_W'(want) < nbanks);
      load_ok  = (kind_ff == KIND_LOAD) && (NBANK_W'(lbank_ff) < NBANK_W'(MAX_BANKS));
      bank_sel = (kind_ff == KIND_LOAD) ? lbank_ff : bank_latch_ff;
      span     = SPAN_W'(bank_sel) * SPAN_W'(PLANE_BYTES) + SPAN_W'(off_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.divide) begin
         q_ff <= prod_q[PROD_W-1:24];
      end
      if (cmd.remainder) begin
         off_ff     <= OFF_W'(rem_b);
         mem_ans_ff <= mem_ans;
         ph_drv_ff  <= asserts;
      end
      if (cmd.locate) begin
         idx_ff       <= IDX_W'(span);
         ans_ff       <= mem_ans_ff || port_hit;
         rej_ff       <= port_hit && !sel_ok;
         latch_we_ff  <= (port_hit && sel_ok) || (kind_ff == KIND_RESET);
         latch_val_ff <= (kind_ff == KIND_RESET) ? '0 : want;
         store_we_ff  <= (mem_ans_ff && (kind_ff == KIND_MEM_WR)) || load_ok;
         rd_use_ff    <= mem_ans_ff && (kind_ff == KIND_MEM_RD);
      end
   end

   bmbd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store_ram (
      .clock      (clock),
      .wr_en      (cmd.access && store_we_ff),
      .addr       (idx_ff),
      .wr_data    (data_ff),
      .rd_data_ff (store_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_latch_ff <= '0;
      end else if (cmd.access && latch_we_ff) begin
         bank_latch_ff <= latch_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_data_ff <= {1'b0, bank_latch_ff, rej_ff,
                         (rd_use_ff ? store_rd : '0), ph_drv_ff, ans_ff};
      end
   end

endmodule

`default_nettype wire

FILE: dv/tb_banked_memory_board_bus_decode_core.sv
`default_nettype none

module tb_banked_memory_board_bus_decode_core;
   import bmbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0]  KIND_NOP       = 3'd7;
   localparam logic [CARD_W-1:0]  CARD_RSVD6     = 3'd6;
   localparam logic [CARD_W-1:0]  CARD_RSVD7     = 3'd7;
   localparam logic [MODE_W-1:0]  MODE_ALL_ALIAS = 2'd3;
   localparam logic [ATTR_W-1:0]  PAGE_RSVD      = 2'd3;

   localparam int PLAN_ROWS       = 33;
   localparam int PHASES          = 10;
   localparam int PHASE_ITEMS     = 88;
   localparam int SETTLE_CYCLES   = 10;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT     = 2000;
   localparam int MAX_REPORTS     = 10;
   localparam int RECENT_DEPTH    = 48;

   typedef struct packed {
      logic [BANK_W-1:0] load_bank;
      logic [ATTR_W-1:0] page_attr;
      logic              phantom_in;
      logic [DATA_W-1:0] data;
      logic [ADDR_W-1:0] address;
   } cycle_fields_type;

   typedef struct packed {
      logic [BANK_W-1:0] current_bank;
      logic              select_rejected;
      logic [DATA_W-1:0] read_data;
      logic              phantom_driven;
      logic              answered;
   } bus_answer_type;

   typedef struct packed {
      logic                  typed;
      logic [KIND_W-1:0]     kind;
      logic [ADDR_W-1:0]     address;
      logic [DATA_W-1:0]     data;
      logic                  phantom_in;
      logic [ATTR_W-1:0]     page_attr;
      logic [BANK_W-1:0]     load_bank;
      logic                  e_answered;
      logic                  e_phantom;
      logic [DATA_W-1:0]     e_read;
      logic                  e_rejected;
      logic [BANK_W-1:0]     e_bank;
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]      req_tuser = KIND_NOP;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_CARD_TYPE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic quiet = 1'b0;
   logic hold_pending = 1'b0;
   logic hold_done = 1'b0;

   logic [ATTR_W-1:0]  page_attr_tbl [PAGES];
   logic [BANK_W-1:0]  bank_sel;
   logic [CARD_W-1:0]  card_sel;
   logic [MODE_W-1:0]  honor_sel;
   logic [MODE_W-1:0]  assert_sel;
   logic [DATA_W-1:0]  plane_bytes [int];
   logic [ADDR_W-1:0]  recent_addr [$];
   logic [PAGE_W-1:0]  work_page [8];
   bus_answer_type     answer_q [$];
   int                 mismatches = 0;
   int                 stuck_cycles = 0;

   plan_row_type plan [0:PLAN_ROWS-1] = '{
      '{1, KIND_LOAD,     'h0000, 'hA5, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_MEM_RD,   'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_SET_PAGE, 'h0000, 'h00, 0, PAGE_RAM,  0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_MEM_RD,   'h0000, 'h00, 0, PAGE_NONE, 0, 1, 0, 'hA5, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_MEM_WR,   'h00FF, 'hFF, 0, PAGE_NONE, 0, 1, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_SET_PAGE, 'hFF00, 'h00, 0, PAGE_ROM,  0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_LOAD,     'hFFFF, 'h5A, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_MEM_RD,   'hFFFF, 'h00, 1, PAGE_NONE, 0, 1, 0, 'h5A, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_HONOR, MODE_ALL},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_ASSERT, MODE_READS},
      '{1, KIND_MEM_RD,   'hFFFF, 'h00, 1, PAGE_NONE, 0, 1, 1, 'h5A, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_MEM_WR,   'hFFFF, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_MEM_RD,   'h0000, 'h00, 1, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_SET_PAGE, 'h0000, 'h00, 0, PAGE_RSVD, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_MEM_RD,   'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_CARD_TYPE,
        CARD_ERAM},
      '{1, KIND_IO_WR,    'h12FF, 'hFF, 0, PAGE_NONE, 0, 1, 0, 'h00, 0, 7, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_IO_RD,    'h00FF, 'h01, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 7, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_CARD_TYPE,
        CARD_VRAM},
      '{1, KIND_IO_WR,    'h0040, 'h40, 0, PAGE_NONE, 0, 1, 0, 'h00, 1, 7, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_IO_WR,    'h0040, 'h42, 0, PAGE_NONE, 0, 1, 0, 'h00, 0, 1, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_IO_WR,    'h0040, 'h03, 0, PAGE_NONE, 0, 1, 0, 'h00, 1, 1, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_CARD_TYPE,
        CARD_CRAM},
      '{1, KIND_IO_WR,    'h0040, 'h80, 0, PAGE_NONE, 0, 1, 0, 'h00, 1, 1, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_IO_WR,    'h0040, 'hC0, 0, PAGE_NONE, 0, 1, 0, 'h00, 0, 6, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_CARD_TYPE,
        CARD_HRAM},
      '{1, KIND_IO_WR,    'hFFC0, 'hFF, 0, PAGE_NONE, 0, 1, 0, 'h00, 0, 15, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_CARD_TYPE,
        CARD_B810},
      '{0, KIND_IO_WR,    'h0040, 'h0E, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_NOP,      'h0040, 'h0E, 1, PAGE_ROM,  9, 0, 0, 'h00, 0, 14, 0, CSR_CARD_TYPE, 0},
      '{1, KIND_RESET,    'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0},
      '{0, KIND_NOP,      'h0000, 'h00, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 1, CSR_CARD_TYPE,
        CARD_RSVD7},
      '{1, KIND_IO_WR,    'h0000, 'h01, 0, PAGE_NONE, 0, 0, 0, 'h00, 0, 0, 0, CSR_CARD_TYPE, 0}
   };

   logic [CARD_W-1:0] phase_card [PHASES] = '{CARD_ERAM, CARD_VRAM, CARD_CRAM, CARD_HRAM,
      CARD_B810, CARD_RSVD7, CARD_NONE, CARD_RSVD6, CARD_B810, CARD_VRAM};
   logic [MODE_W-1:0] phase_honor [PHASES] = '{MODE_NEVER, MODE_READS, MODE_ALL,
      MODE_ALL_ALIAS, MODE_NEVER, MODE_ALL, MODE_READS, MODE_ALL_ALIAS, MODE_READS, MODE_ALL};
   logic [MODE_W-1:0] phase_assert [PHASES] = '{MODE_NEVER, MODE_READS, MODE_ALL,
      MODE_ALL_ALIAS, MODE_ALL, MODE_NEVER, MODE_ALL_ALIAS, MODE_READS, MODE_ALL, MODE_READS};

   banked_memory_board_bus_decode_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int store_key(input logic [BANK_W-1:0] bank,
                                    input logic [ADDR_W-1:0] addr);
      return int'({bank, addr});
   endfunction

   function automatic logic [DATA_W-1:0] bank_port(input logic [CARD_W-1:0] card);
      case (card)
         CARD_ERAM: return 8'hFF;
         CARD_VRAM, CARD_CRAM, CARD_B810: return 8'h40;
         CARD_HRAM: return 8'hC0;
         default: return 8'h00;
      endcase
   endfunction

   function automatic int gap_cycles();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 70) return int'($urandom_range(1, 2));
      if (roll < 95) return int'($urandom_range(3, 8));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      int roll;
      logic [7:0] low;
      roll = int'($urandom_range(0, 9));
      low = 8'($urandom_range(0, 255));
      if (roll == 0) begin
         low = 8'h00;
      end else if (roll == 1) begin
         low = 8'hFF;
      end
      return {work_page[$urandom_range(0, 7)], low};
   endfunction

   // Advances the card state by one accepted item and returns the answer it produces.
   function automatic bus_answer_type predict_bus_cycle(input logic [KIND_W-1:0] kind,
                                                        input cycle_fields_type f);
      bus_answer_type r;
      logic [ATTR_W-1:0] pk;
      logic rd_cyc, rom, asserts, honors, has_port, one_hot, ok;
      logic [DATA_W-1:0] mask, sel;
      int nbanks, want, key;
      r = '0;
      key = store_key(bank_sel, f.address);
      case (kind)
         KIND_MEM_RD, KIND_MEM_WR: begin
            pk = page_attr_tbl[f.address[15:8]];
            rd_cyc = (kind == KIND_MEM_RD);
            rom = (pk == PAGE_ROM);
            asserts = rom && (assert_sel >= MODE_ALL || (assert_sel == MODE_READS && rd_cyc));
            honors = honor_sel >= MODE_ALL || (honor_sel == MODE_READS && rd_cyc);
            r.phantom_driven = asserts;
            if (!(f.phantom_in && honors && !asserts) && pk != PAGE_NONE && !(!rd_cyc && rom))
            begin
               r.answered = 1'b1;
               if (rd_cyc) begin
                  r.read_data = plane_bytes[key];
               end else begin
                  plane_bytes[key] = f.data;
               end
            end
         end
         KIND_IO_WR: begin
            has_port = 1'b1;
            one_hot = 1'b0;
            mask = 8'hFF;
            nbanks = 1;
            case (card_sel)
               CARD_ERAM: begin mask = 8'h07; nbanks = 8; end
               CARD_VRAM: begin mask = 8'hFF; nbanks = 8; one_hot = 1'b1; end
               CARD_CRAM: begin mask = 8'h7F; nbanks = 7; one_hot = 1'b1; end
               CARD_HRAM, CARD_B810: begin mask = 8'h0F; nbanks = 16; end
               default: has_port = 1'b0;
            endcase
            if (nbanks > MAX_BANKS_DEF) nbanks = MAX_BANKS_DEF;
            if (has_port && f.address[7:0] == bank_port(card_sel)) begin
               r.answered = 1'b1;
               sel = f.data & mask;
               ok = 1'b0;
               want = 0;
               if (!one_hot) begin
                  want = int'(sel);
                  ok = 1'b1;
               end else begin
                  if (card_sel == CARD_VRAM) sel = sel & VRAM_BIT6_MASK;
                  for (int i = 0; i < 8; i++) begin
                     if (!ok && sel == (8'd1 << i)) begin
                        want = i;
                        ok = 1'b1;
                     end
                  end
               end
               if (ok && want < nbanks) begin
                  bank_sel = want[BANK_W-1:0];
               end else begin
                  r.select_rejected = 1'b1;
               end
            end
         end
         KIND_SET_PAGE: begin
            page_attr_tbl[f.address[15:8]] =
               (f.page_attr == PAGE_RAM || f.page_attr == PAGE_ROM) ? f.page_attr : PAGE_NONE;
         end
         KIND_RESET: bank_sel = '0;
         KIND_LOAD: plane_bytes[store_key(f.load_bank, f.address)] = f.data;
         default: ;
      endcase
      r.current_bank = bank_sel;
      return r;
   endfunction

   // Reads are steered to bytes that hold a known value in the selected plane;
   // where none is known yet, the item becomes a load of that byte instead.
   task automatic make_random_cycle(output logic [KIND_W-1:0] kind,
                                    output cycle_fields_type f);
      int roll;
      logic [DATA_W-1:0] port;
      f = cycle_fields_type'(31'($urandom()));
      roll = int'($urandom_range(0, 99));
      if (roll < 28) kind = KIND_MEM_RD;
      else if (roll < 46) kind = KIND_MEM_WR;
      else if (roll < 62) kind = KIND_IO_WR;
      else if (roll < 76) kind = KIND_LOAD;
      else if (roll < 88) kind = KIND_SET_PAGE;
      else if (roll < 92) kind = KIND_IO_RD;
      else if (roll < 96) kind = KIND_RESET;
      else kind = KIND_NOP;
      case (kind)
         KIND_MEM_RD: begin
            if (recent_addr.size() != 0 && $urandom_range(0, 9) < 7) begin
               f.address = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
            end else begin
               f.address = pick_address();
            end
            if (!plane_bytes.exists(store_key(bank_sel, f.address))) begin
               kind = KIND_LOAD;
               f.load_bank = bank_sel;
            end
         end
         KIND_MEM_WR, KIND_LOAD: f.address = pick_address();
         KIND_SET_PAGE: begin
            f.address = pick_address();
            roll = int'($urandom_range(0, 99));
            if (roll < 40) f.page_attr = PAGE_RAM;
            else if (roll < 70) f.page_attr = PAGE_ROM;
            else if (roll < 85) f.page_attr = PAGE_NONE;
            else f.page_attr = PAGE_RSVD;
         end
         KIND_IO_WR: begin
            port = bank_port(card_sel);
            if ($urandom_range(0, 9) < 7) f.address[7:0] = port;
            if ((card_sel == CARD_VRAM || card_sel == CARD_CRAM) && $urandom_range(0, 9) < 6)
            begin
               f.data = 8'd1 << $urandom_range(0, 7);
               if (card_sel == CARD_VRAM && $urandom_range(0, 1) == 1) f.data = f.data | 8'h40;
            end
         end
         default: ;
      endcase
      if (kind == KIND_LOAD || kind == KIND_MEM_WR) begin
         recent_addr = {recent_addr, f.address};
         if (recent_addr.size() > RECENT_DEPTH) void'(recent_addr.pop_front());
      end
   endtask

   task automatic send_cycle(input logic [KIND_W-1:0] kind, input cycle_fields_type f,
                             input logic use_typed, input bus_answer_type typed_ans);
      bus_answer_type predicted;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, f};
      do @(posedge clock); while (!req_tready);
      predicted = predict_bus_cycle(kind, f);
      answer_q = {answer_q, (use_typed ? typed_ans : predicted)};
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles()) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CARD_TYPE: card_sel = val;
         CSR_HONOR: honor_sel = val[MODE_W-1:0];
         CSR_ASSERT: assert_sel = val[MODE_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input bus_answer_type want,
                                  input bus_answer_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $write("%0t: %s: expected ans=%0b ph=%0b rd=%02h rej=%0b bank=%0d, ",
                $realtime, what, want.answered, want.phantom_driven, want.read_data,
                want.select_rejected, want.current_bank);
         $display("got ans=%0b ph=%0b rd=%02h rej=%0b bank=%0d",
                  got.answered, got.phantom_driven, got.read_data, got.select_rejected,
                  got.current_bank);
      end
   endtask

   always @(posedge clock) begin
      bus_answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(bus_answer_type)-1:0];
         if (answer_q.size() == 0) begin
            report_mismatch("transfer with no answer pending", '0, got);
         end else begin
            want = answer_q.pop_front();
            if (got.answered !== want.answered || got.phantom_driven !== want.phantom_driven ||
                got.read_data !== want.read_data ||
                got.select_rejected !== want.select_rejected ||
                got.current_bank !== want.current_bank) begin
               report_mismatch("answer mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb_banked_memory_board_bus_decode_core NOT OK");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // The long hold lets the result register and the item in work back up,
   // so the input side stalls while the sender keeps a transfer offered.
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_pending && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_cycles()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [KIND_W-1:0] kind;
      cycle_fields_type f;
      bus_answer_type typed_ans;
      for (int i = 0; i < PAGES; i++) page_attr_tbl[i] = PAGE_NONE;
      bank_sel = '0;
      card_sel = CARD_NONE;
      honor_sel = MODE_NEVER;
      assert_sel = MODE_NEVER;
      for (int i = 0; i < 8; i++) work_page[i] = PAGE_W'($urandom_range(0, 255));
      work_page[0] = 8'h00;
      work_page[1] = 8'hFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (plan[r].is_csr) begin
            settle();
            write_reg(plan[r].csr_idx, plan[r].csr_val);
         end else begin
            f = '{load_bank: plan[r].load_bank, page_attr: plan[r].page_attr,
                  phantom_in: plan[r].phantom_in, data: plan[r].data,
                  address: plan[r].address};
            typed_ans = '{current_bank: plan[r].e_bank, select_rejected: plan[r].e_rejected,
                          read_data: plan[r].e_read, phantom_driven: plan[r].e_phantom,
                          answered: plan[r].e_answered};
            send_cycle(plan[r].kind, f, plan[r].typed, typed_ans);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_reg(CSR_CARD_TYPE, phase_card[p]);
         write_reg(CSR_HONOR, phase_honor[p]);
         write_reg(CSR_ASSERT, phase_assert[p]);
         quiet <= (p == 1 || p == 6);
         hold_pending <= (p == 3);
         work_page[6] = PAGE_W'($urandom_range(0, 255));
         work_page[7] = PAGE_W'($urandom_range(0, 255));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            make_random_cycle(kind, f);
            send_cycle(kind, f, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("tb_banked_memory_board_bus_decode_core OK");
      end else begin
         $display("tb_banked_memory_board_bus_decode_core NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
